// ===== rtl/core/base64_encoder_line_wrap_assert.svh =====
// Assertion macros used by the checker of the Base64 encoder.
`ifndef BASE64_ENCODER_LINE_WRAP_ASSERT_SVH
`define BASE64_ENCODER_LINE_WRAP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define B64LW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 encoder check failed");

// The consequent must hold in the same cycle as the antecedent.
`define B64LW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 encoder check failed");

`endif

// ===== rtl/core/b64lw_pkg.sv =====
// Package of the Base64 encoder: item types, constants and the symbol mapping function.
package b64lw_pkg;

    // Width of the saturating line length counter.
    localparam int LINE_COUNT_BITS = 16;
    localparam int MAX_LINE_BITS   = 16;
    localparam int CMP_BITS = ((LINE_COUNT_BITS > MAX_LINE_BITS) ?
                               LINE_COUNT_BITS : MAX_LINE_BITS) + 1;
    localparam logic [LINE_COUNT_BITS-1:0] COUNT_MAX = '1;

    // Fixed characters.
    localparam logic [7:0] CR_CHAR  = 8'h0d;
    localparam logic [7:0] LF_CHAR  = 8'h0a;
    localparam logic [7:0] PAD_CHAR = 8'h3d;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYM62    = 2'd0;
    localparam logic [1:0] CFG_SYM63    = 2'd1;
    localparam logic [1:0] CFG_MAX_LINE = 2'd2;

    // Output steps of one group: line break first, then four characters.
    localparam logic [2:0] STEP_CR = 3'd0;
    localparam logic [2:0] STEP_LF = 3'd1;
    localparam logic [2:0] STEP_C0 = 3'd2;
    localparam logic [2:0] STEP_C1 = 3'd3;
    localparam logic [2:0] STEP_C2 = 3'd4;
    localparam logic [2:0] STEP_C3 = 3'd5;

    // Group length codes.
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } out_item_t;

    // One classified group handed from the front to the back.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
        logic       crlf;
    } group_t;

    // Maps a six-bit value to its Base64 character.
    function automatic logic [7:0] six_to_char(input logic [5:0] v,
                                               input logic [7:0] sym62,
                                               input logic [7:0] sym63);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (w < 8'd26)
            c = 8'd65 + w;
        else if (w < 8'd52)
            c = 8'd97 + (w - 8'd26);
        else if (w < 8'd62)
            c = 8'd48 + (w - 8'd52);
        else if (w == 8'd62)
            c = sym62;
        else
            c = sym63;
        return c;
    endfunction

endpackage

// ===== rtl/core/b64lw_fifo.sv =====
// Two-entry queue of classified groups between the front and the back.
module b64lw_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64lw_pkg::group_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output b64lw_pkg::group_t head
);

    b64lw_pkg::group_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

endmodule

// ===== rtl/core/b64lw_front.sv =====
// Front part: gathers bytes into groups and decides line breaks.
module b64lw_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  b64lw_pkg::in_item_t item,
    input  logic [15:0]         max_line,
    output logic                push,
    output b64lw_pkg::group_t   group
);

    localparam int LCB = b64lw_pkg::LINE_COUNT_BITS;
    localparam int CW  = b64lw_pkg::CMP_BITS;

    logic [7:0]     pend0_reg, pend0_next;
    logic [7:0]     pend1_reg, pend1_next;
    logic [1:0]     pcount_reg, pcount_next;
    logic [LCB-1:0] line_reg, line_next;

    logic           complete;
    logic           crlf;
    logic [CW-1:0]  line_plus4;
    logic [LCB-1:0] base;
    logic [LCB:0]   base_plus4;

    // Group is complete on the third byte or at the end of the message.
    assign complete = item.end_of_data || (pcount_reg == 2'd2);
    assign push     = accept && complete;

    // Line break decision and saturating line count.
    always_comb
    begin
        line_plus4 = CW'(line_reg) + CW'(4);
        crlf       = (max_line != 16'd0) && (line_plus4 > CW'(max_line));
        base       = crlf ? '0 : line_reg;
        base_plus4 = {1'b0, base} + (LCB+1)'(4);
    end

    // Group contents, zero-filled for a short group.
    always_comb
    begin
        group.crlf = crlf;
        case (pcount_reg)
            2'd0:
            begin
                group.b0  = item.data_byte;
                group.b1  = 8'd0;
                group.b2  = 8'd0;
                group.len = b64lw_pkg::LEN_ONE;
            end
            2'd1:
            begin
                group.b0  = pend0_reg;
                group.b1  = item.data_byte;
                group.b2  = 8'd0;
                group.len = b64lw_pkg::LEN_TWO;
            end
            default:
            begin
                group.b0  = pend0_reg;
                group.b1  = pend1_reg;
                group.b2  = item.data_byte;
                group.len = b64lw_pkg::LEN_THREE;
            end
        endcase
    end

    // State update on each accepted item.
    always_comb
    begin
        pend0_next  = pend0_reg;
        pend1_next  = pend1_reg;
        pcount_next = pcount_reg;
        line_next   = line_reg;
        if (accept)
        begin
            if (!complete)
            begin
                if (pcount_reg[0])
                    pend1_next = item.data_byte;
                else
                    pend0_next = item.data_byte;
                pcount_next = pcount_reg + 2'd1;
            end
            else
            begin
                pcount_next = 2'd0;
                if (item.end_of_data)
                    line_next = '0;
                else if (base_plus4 > {1'b0, b64lw_pkg::COUNT_MAX})
                    line_next = b64lw_pkg::COUNT_MAX;
                else
                    line_next = base_plus4[LCB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            line_reg   <= '0;
        end
        else
        begin
            pcount_reg <= pcount_next;
            line_reg   <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

// ===== rtl/core/b64lw_back.sv =====
// Back part: turns queued groups into characters, one per cycle while char_stall is low.
module b64lw_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  b64lw_pkg::group_t    head,
    input  logic [7:0]           sym62,
    input  logic [7:0]           sym63,
    output logic                 pop,
    output logic                 char_valid,
    input  logic                 char_stall,
    output b64lw_pkg::out_item_t char_item
);

    logic [2:0]           step_reg, step_next;
    logic                 valid_reg, valid_next;
    b64lw_pkg::out_item_t item_reg, item_next;

    logic                 advance;
    logic                 emit;
    logic [2:0]           eff_step;
    logic [5:0]           s0, s1, s2, s3;
    logic [7:0]           ch;

    // Output register may load when empty or being taken.
    assign advance  = !valid_reg || !char_stall;
    assign emit     = advance && head_valid;
    assign eff_step = (step_reg == b64lw_pkg::STEP_CR && !head.crlf) ?
                      b64lw_pkg::STEP_C0 : step_reg;
    assign pop      = emit && (eff_step == b64lw_pkg::STEP_C3);

    // Six-bit fields of the group.
    assign s0 = head.b0[7:2];
    assign s1 = {head.b0[1:0], head.b1[7:4]};
    assign s2 = {head.b1[3:0], head.b2[7:6]};
    assign s3 = head.b2[5:0];

    // Character for the current step.
    always_comb
    begin
        case (eff_step)
            b64lw_pkg::STEP_CR: ch = b64lw_pkg::CR_CHAR;
            b64lw_pkg::STEP_LF: ch = b64lw_pkg::LF_CHAR;
            b64lw_pkg::STEP_C0: ch = b64lw_pkg::six_to_char(s0, sym62, sym63);
            b64lw_pkg::STEP_C1: ch = b64lw_pkg::six_to_char(s1, sym62, sym63);
            b64lw_pkg::STEP_C2:
                ch = (head.len == b64lw_pkg::LEN_ONE) ? b64lw_pkg::PAD_CHAR :
                     b64lw_pkg::six_to_char(s2, sym62, sym63);
            default:
                ch = (head.len != b64lw_pkg::LEN_THREE) ? b64lw_pkg::PAD_CHAR :
                     b64lw_pkg::six_to_char(s3, sym62, sym63);
        endcase
    end

    // Step counter and output register.
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (advance)
            valid_next = head_valid;
        if (emit)
        begin
            item_next.out_char = ch;
            item_next.run_last = (eff_step == b64lw_pkg::STEP_C3);
            step_next = (eff_step == b64lw_pkg::STEP_C3) ? b64lw_pkg::STEP_CR :
                        eff_step + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= b64lw_pkg::STEP_CR;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign char_valid = valid_reg;
    assign char_item  = item_reg;

endmodule

// ===== rtl/core/base64_encoder_line_wrap.sv =====
// Top level of the Base64 encoder with CR LF line wrapping.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  byte     | byte_valid, byte_stall  | byte_item (data_byte, end_of_data)
//  char     | char_valid, char_stall  | char_item (out_char, run_last)
//  config   | cfg_write               | cfg_index, cfg_data
//
// Each byte is taken while the group queue has room; characters leave at one
// item per cycle while groups are queued and char_stall is low, through the
// single output register of the back part: four per three bytes, two per break.
// Reset clears the byte gathering, line count, queue and output register.
// A full two-entry group queue stalls the byte channel; char_stall holds the
// output register and the back part.
module base64_encoder_line_wrap
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  b64lw_pkg::in_item_t  byte_item,
    output logic                 char_valid,
    input  logic                 char_stall,
    output b64lw_pkg::out_item_t char_item,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [7:0]        sym62_reg, sym62_next;
    logic [7:0]        sym63_reg, sym63_next;
    logic [15:0]       max_line_reg, max_line_next;

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              not_empty;
    b64lw_pkg::group_t push_group;
    b64lw_pkg::group_t head;

    // Configuration registers.
    always_comb
    begin
        sym62_next    = sym62_reg;
        sym63_next    = sym63_reg;
        max_line_next = max_line_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                b64lw_pkg::CFG_SYM62:    sym62_next    = cfg_data[7:0];
                b64lw_pkg::CFG_SYM63:    sym63_next    = cfg_data[7:0];
                b64lw_pkg::CFG_MAX_LINE: max_line_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym62_reg    <= 8'd43;
            sym63_reg    <= 8'd47;
            max_line_reg <= 16'd0;
        end
        else
        begin
            sym62_reg    <= sym62_next;
            sym63_reg    <= sym63_next;
            max_line_reg <= max_line_next;
        end
    end

    // Bytes wait only while the group queue is full.
    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    b64lw_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (byte_item),
        .max_line (max_line_reg),
        .push     (push),
        .group    (push_group)
    );

    b64lw_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_group),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    b64lw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .sym62      (sym62_reg),
        .sym63      (sym63_reg),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

// ===== rtl/core/b64lw_checker.sv =====
// Port checker of the Base64 encoder and its bind to the top level.
`include "base64_encoder_line_wrap_assert.svh"

module b64lw_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 byte_valid,
    input logic                 byte_stall,
    input b64lw_pkg::in_item_t  byte_item,
    input logic                 char_valid,
    input logic                 char_stall,
    input b64lw_pkg::out_item_t char_item
);

    // A stalled byte item stays offered with the same payload.
    `B64LW_ASSERT_NEXT(a_byte_hold, byte_valid && byte_stall, byte_valid && $stable(byte_item))

    // A stalled item stays offered.
    `B64LW_ASSERT_NEXT(a_char_hold, char_valid && char_stall, char_valid)

    // A stalled item keeps its payload.
    `B64LW_ASSERT_NEXT(a_char_stable, char_valid && char_stall, $stable(char_item))

    // Characters of one group come without gaps once taken.
    `B64LW_ASSERT_NEXT(a_group_burst, char_valid && !char_stall && !char_item.run_last,
                       char_valid)

    // The byte side stalls only while queued groups have characters on offer.
    `B64LW_ASSERT_SAME(a_stall_needs_output, byte_stall, char_valid || $past(char_valid))

endmodule

bind base64_encoder_line_wrap b64lw_checker u_b64lw_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
);
